>>> rtl/lts_pkg.sv
// ============================================================================
// lts_pkg
// Shared widths, reset values, codes and payload types of the Lorenz
// trajectory stepper.
// ============================================================================
`default_nettype none

package lts_pkg;

    // Default parameter values
    localparam int HISTORY_DEPTH_DEF = 512;
    localparam int TRAJECTORIES_DEF  = 5;

    // Field widths
    localparam int FRAC_BITS  = 24;
    localparam int COORD_W    = 32;
    localparam int GAIN_W     = 31;
    localparam int STEP_W     = 24;
    localparam int RATE_W     = 40;
    localparam int TRAJ_W     = 3;
    localparam int SLOT_OUT_W = 9;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Digit-serial multiplier geometry
    localparam int DIGIT_W    = 8;
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = 40;
    localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
    localparam int MUL_ACC_W  = 50;
    localparam int MUL_LO_W   = MUL_DIGITS * DIGIT_W - FRAC_BITS;
    localparam int MUL_P_W    = 57;

    // Rate / coordinate summing width
    localparam int ACC_W = 59;

    localparam logic signed [ACC_W-1:0] RATE_HI  = ACC_W'(64'sh0000_007F_FFFF_FFFF);
    localparam logic signed [ACC_W-1:0] RATE_LO  = ACC_W'(-64'sh0000_0080_0000_0000);
    localparam logic signed [ACC_W-1:0] COORD_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] COORD_LO = ACC_W'(-64'sh0000_0000_8000_0000);

    // Register reset values
    localparam logic [GAIN_W-1:0] SIGMA_RST = 31'd167772160;
    localparam logic [GAIN_W-1:0] RHO_RST   = 31'd469762048;
    localparam logic [GAIN_W-1:0] BETA_RST  = 31'd44739243;
    localparam logic [STEP_W-1:0] DT_RST    = 24'd50332;

    typedef enum logic [1:0] {
        REG_SIGMA     = 2'd0,
        REG_RHO       = 2'd1,
        REG_BETA      = 2'd2,
        REG_TIME_STEP = 2'd3
    } lts_reg_t;

    typedef enum logic {
        OPC_STEP = 1'b0,
        OPC_LOAD = 1'b1
    } lts_opcode_t;

    // One product per code, in schedule order
    typedef enum logic [2:0] {
        OP_RATE_X    = 3'd0,
        OP_RATE_Y_LN = 3'd1,
        OP_RATE_Y    = 3'd2,
        OP_RATE_Z_XY = 3'd3,
        OP_RATE_Z    = 3'd4,
        OP_STEP_X    = 3'd5,
        OP_STEP_Y    = 3'd6,
        OP_STEP_Z    = 3'd7
    } lts_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ISSUE,
        ST_MUL,
        ST_SUM,
        ST_CLAMP,
        ST_WRITE,
        ST_RESULT
    } lts_state_t;

    typedef struct packed {
        logic                      operation;
        logic [TRAJ_W-1:0]         trajectory;
        logic signed [COORD_W-1:0] load_x;
        logic signed [COORD_W-1:0] load_y;
        logic signed [COORD_W-1:0] load_z;
    } lts_in_t;

    typedef struct packed {
        logic [TRAJ_W-1:0]         trajectory_out;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [SLOT_OUT_W-1:0]     history_slot;
        logic                      saturated;
    } lts_out_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } lts_mul_cmd_t;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] product;
    } lts_mul_rsp_t;

endpackage

`default_nettype wire

>>> rtl/lts_digit_mul.sv
// ============================================================================
// lts_digit_mul
// Digit-serial signed multiplier, one 8-bit digit of b per cycle, returning
// the product rounded half up to Q8.24.
// ============================================================================
`default_nettype none

module lts_digit_mul import lts_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  lts_mul_cmd_t cmd,
    output lts_mul_rsp_t rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [MUL_CNT_W-1:0]        cnt_reg;
    logic signed [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]          b_reg;
    logic signed [MUL_ACC_W-1:0] hi_reg;
    logic [MUL_LO_W-1:0]         lo_reg;

    logic                        last;
    logic signed [DIGIT_W:0]     digit;
    logic signed [MUL_ACC_W-1:0] pp;
    logic signed [MUL_ACC_W:0]   sum;
    logic signed [MUL_ACC_W:0]   sum_sh;
    logic signed [MUL_ACC_W-1:0] hi_next;
    logic [MUL_LO_W-1:0]         lo_next;

    // Top digit carries the sign of b
    assign last  = (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1));
    assign digit = {last & b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]};
    assign pp    = a_reg * digit;
    assign sum   = {hi_reg[MUL_ACC_W-1], hi_reg} + {pp[MUL_ACC_W-1], pp};
    assign sum_sh  = sum >>> DIGIT_W;
    assign hi_next = sum_sh[MUL_ACC_W-1:0];
    assign lo_next = {sum[DIGIT_W-1:0], lo_reg[MUL_LO_W-1:DIGIT_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg & last;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                busy_reg <= ~last;
                cnt_reg  <= cnt_reg + MUL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            a_reg  <= cmd.a;
            b_reg  <= cmd.b;
            // seed the rounding half at bit 23
            hi_reg <= MUL_ACC_W'(1) <<< (FRAC_BITS - 1);
        end else if (busy_reg) begin
            b_reg  <= b_reg >> DIGIT_W;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg[MUL_P_W-MUL_LO_W-1:0], lo_reg};

endmodule

`default_nettype wire

>>> rtl/lorenz_trajectory_stepper_core.sv
// ============================================================================
// lorenz_trajectory_stepper_core
// Holds several Lorenz trajectories and advances one by a forward-Euler step,
// or loads a starting point, per request. Q8.24 fixed point with saturation.
// ============================================================================
// Requests: a new request is taken only while idle, once the last result has
//   been loaded into the result register. A step runs the eight products of
//   an Euler step one after another through the single digit-serial
//   multiplier, each through issue, multiply and sum, and all but the two
//   partial products through clamp.
// Reset: synchronous, active low; clears all trajectories to the origin, the
//   history slots to zero and the gains to their defaults.
`default_nettype none

module lorenz_trajectory_stepper_core import lts_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int TRAJECTORIES  = TRAJECTORIES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  lts_in_t                    s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lts_out_t                   m_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int TR_IDX_W = (TRAJECTORIES > 1) ? $clog2(TRAJECTORIES) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] sigma_reg;
    logic [GAIN_W-1:0] rho_reg;
    logic [GAIN_W-1:0] beta_reg;
    logic [STEP_W-1:0] dt_reg;
    logic              cfg_we;
    lts_reg_t          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_sel = lts_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RST;
            rho_reg   <= RHO_RST;
            beta_reg  <= BETA_RST;
            dt_reg    <= DT_RST;
        end else if (cfg_we) begin
            unique case (cfg_sel)
                REG_SIGMA:     sigma_reg <= pwdata[GAIN_W-1:0];
                REG_RHO:       rho_reg   <= pwdata[GAIN_W-1:0];
                REG_BETA:      beta_reg  <= pwdata[GAIN_W-1:0];
                REG_TIME_STEP: dt_reg    <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback, zero-extended to the bus
    always_comb begin
        unique case (cfg_sel)
            REG_SIGMA:     prdata = APB_DATA_W'(sigma_reg);
            REG_RHO:       prdata = APB_DATA_W'(rho_reg);
            REG_BETA:      prdata = APB_DATA_W'(beta_reg);
            REG_TIME_STEP: prdata = APB_DATA_W'(dt_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Trajectory state, one entry per trajectory
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] coord_x_reg [TRAJECTORIES];
    logic signed [COORD_W-1:0] coord_y_reg [TRAJECTORIES];
    logic signed [COORD_W-1:0] coord_z_reg [TRAJECTORIES];
    logic [SLOT_W-1:0]         slot_reg    [TRAJECTORIES];

    // ------------------------------------------------------------------
    // Request and working registers
    // ------------------------------------------------------------------
    lts_state_t                state_reg, state_next;
    lts_op_t                   op_reg;
    lts_in_t                   req_reg;
    logic signed [COORD_W-1:0] xw_reg, yw_reg, zw_reg;
    logic [SLOT_W-1:0]         slotw_reg;
    logic                      sat_reg;
    logic signed [RATE_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      m_valid_reg;
    lts_out_t                  m_data_reg;

    // control outputs of the sequencer
    logic s_ready_c;
    logic mul_start_c;
    logic out_load_c;
    logic state_we_c;

    logic                      in_range;
    logic [TR_IDX_W+TRAJ_W-1:0] tr_wide;
    logic [TR_IDX_W-1:0]       tr_idx;
    logic                      req_accept;

    assign req_accept = s_valid & s_ready_c;
    assign in_range   = (int'(req_reg.trajectory) < TRAJECTORIES);
    assign tr_wide    = {{TR_IDX_W{1'b0}}, req_reg.trajectory};
    assign tr_idx     = tr_wide[TR_IDX_W-1:0];

    // ------------------------------------------------------------------
    // Multiplier operand schedule
    //   x rate:  sigma*(y-x)
    //   y rate:  rho*x - y + x*z
    //   z rate:  x*y + beta*z
    //   then each rate times dt
    // ------------------------------------------------------------------
    lts_mul_cmd_t              mul_cmd;
    lts_mul_rsp_t              mul_rsp;
    logic signed [COORD_W:0]   diff_yx;

    assign diff_yx = {yw_reg[COORD_W-1], yw_reg} - {xw_reg[COORD_W-1], xw_reg};

    always_comb begin
        mul_cmd.start = mul_start_c;
        unique case (op_reg)
            OP_RATE_X: begin
                mul_cmd.a = MUL_A_W'($signed({1'b0, sigma_reg}));
                mul_cmd.b = MUL_B_W'(diff_yx);
            end
            OP_RATE_Y_LN: begin
                mul_cmd.a = MUL_A_W'($signed({1'b0, rho_reg}));
                mul_cmd.b = MUL_B_W'(xw_reg);
            end
            OP_RATE_Y: begin
                mul_cmd.a = MUL_A_W'(xw_reg);
                mul_cmd.b = MUL_B_W'(zw_reg);
            end
            OP_RATE_Z_XY: begin
                mul_cmd.a = MUL_A_W'(xw_reg);
                mul_cmd.b = MUL_B_W'(yw_reg);
            end
            OP_RATE_Z: begin
                mul_cmd.a = MUL_A_W'($signed({1'b0, beta_reg}));
                mul_cmd.b = MUL_B_W'(zw_reg);
            end
            OP_STEP_X: begin
                mul_cmd.a = MUL_A_W'(rx_reg);
                mul_cmd.b = MUL_B_W'($signed({1'b0, dt_reg}));
            end
            OP_STEP_Y: begin
                mul_cmd.a = MUL_A_W'(ry_reg);
                mul_cmd.b = MUL_B_W'($signed({1'b0, dt_reg}));
            end
            OP_STEP_Z: begin
                mul_cmd.a = MUL_A_W'(rz_reg);
                mul_cmd.b = MUL_B_W'($signed({1'b0, dt_reg}));
            end
            default: begin
                mul_cmd.a = '0;
                mul_cmd.b = '0;
            end
        endcase
    end

    lts_digit_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .rsp     (mul_rsp)
    );

    // ------------------------------------------------------------------
    // Sum: fold the rounded product into the running term
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_next;

    assign prod_ext = ACC_W'(mul_rsp.product);

    always_comb begin
        unique case (op_reg) inside
            OP_RATE_X, OP_RATE_Z_XY: base = '0;
            OP_RATE_Y_LN:            base = -ACC_W'(yw_reg);
            OP_RATE_Y, OP_RATE_Z:    base = acc_reg;
            OP_STEP_X:               base = ACC_W'(xw_reg);
            OP_STEP_Y:               base = ACC_W'(yw_reg);
            OP_STEP_Z:               base = ACC_W'(zw_reg);
            default:                 base = '0;
        endcase
        // z moves against its rate
        acc_next = (op_reg == OP_STEP_Z) ? (base - prod_ext) : (base + prod_ext);
    end

    // ------------------------------------------------------------------
    // Clamp: rates to 40 bits, coordinates to 32 bits
    // ------------------------------------------------------------------
    logic                    clamp_rate;
    logic signed [ACC_W-1:0] lim_hi, lim_lo;
    logic                    over, under;
    logic signed [ACC_W-1:0] clamp_next;

    always_comb begin
        unique case (op_reg) inside
            OP_RATE_X, OP_RATE_Y, OP_RATE_Z: clamp_rate = 1'b1;
            default:                         clamp_rate = 1'b0;
        endcase
        lim_hi = clamp_rate ? RATE_HI : COORD_HI;
        lim_lo = clamp_rate ? RATE_LO : COORD_LO;
        over   = (acc_reg > lim_hi);
        under  = (acc_reg < lim_lo);
        if (over) begin
            clamp_next = lim_hi;
        end else if (under) begin
            clamp_next = lim_lo;
        end else begin
            clamp_next = acc_reg;
        end
    end

    // history slot advance with wrap at the ring depth
    logic [SLOT_W:0]   slot_inc;
    logic [SLOT_W-1:0] slot_next;

    assign slot_inc  = {1'b0, slotw_reg} + (SLOT_W + 1)'(1);
    assign slot_next = (slot_inc >= (SLOT_W + 1)'(HISTORY_DEPTH)) ? '0 : slot_inc[SLOT_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_FETCH;
            end
            ST_FETCH: begin
                if (!in_range) begin
                    state_next = ST_RESULT;
                end else if (req_reg.operation == OPC_LOAD) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = ST_MUL;
            ST_MUL: begin
                if (mul_rsp.done) state_next = ST_SUM;
            end
            ST_SUM: begin
                if (op_reg == OP_RATE_Y_LN || op_reg == OP_RATE_Z_XY) begin
                    state_next = ST_ISSUE;
                end else begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                state_next = (op_reg == OP_STEP_Z) ? ST_WRITE : ST_ISSUE;
            end
            ST_WRITE: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready_c   = 1'b0;
        mul_start_c = 1'b0;
        out_load_c  = 1'b0;
        state_we_c  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready_c   = 1'b1;
            ST_ISSUE:  mul_start_c = 1'b1;
            ST_WRITE:  state_we_c  = 1'b1;
            ST_RESULT: out_load_c  = ~m_valid_reg | m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Working datapath
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_RATE_X;
        end else begin
            unique case (state_reg)
                ST_FETCH: op_reg <= OP_RATE_X;
                ST_SUM: begin
                    if (op_reg == OP_RATE_Y_LN || op_reg == OP_RATE_Z_XY) begin
                        op_reg <= lts_op_t'(op_reg + 3'd1);
                    end
                end
                ST_CLAMP: begin
                    if (op_reg != OP_STEP_Z) op_reg <= lts_op_t'(op_reg + 3'd1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (req_accept) req_reg <= s_data;
        unique case (state_reg)
            ST_FETCH: begin
                sat_reg <= 1'b0;
                if (!in_range) begin
                    // report the origin for a trajectory that does not exist
                    xw_reg    <= '0;
                    yw_reg    <= '0;
                    zw_reg    <= '0;
                    slotw_reg <= '0;
                end else if (req_reg.operation == OPC_LOAD) begin
                    xw_reg    <= req_reg.load_x;
                    yw_reg    <= req_reg.load_y;
                    zw_reg    <= req_reg.load_z;
                    slotw_reg <= '0;
                end else begin
                    xw_reg    <= coord_x_reg[tr_idx];
                    yw_reg    <= coord_y_reg[tr_idx];
                    zw_reg    <= coord_z_reg[tr_idx];
                    slotw_reg <= slot_reg[tr_idx];
                end
            end
            ST_SUM: acc_reg <= acc_next;
            ST_CLAMP: begin
                sat_reg <= sat_reg | over | under;
                unique case (op_reg)
                    OP_RATE_X: rx_reg <= clamp_next[RATE_W-1:0];
                    OP_RATE_Y: ry_reg <= clamp_next[RATE_W-1:0];
                    OP_RATE_Z: rz_reg <= clamp_next[RATE_W-1:0];
                    // x is no longer needed once its own update is formed
                    OP_STEP_X: xw_reg <= clamp_next[COORD_W-1:0];
                    OP_STEP_Y: yw_reg <= clamp_next[COORD_W-1:0];
                    OP_STEP_Z: begin
                        zw_reg    <= clamp_next[COORD_W-1:0];
                        slotw_reg <= slot_next;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Commit the new point to the addressed trajectory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TRAJECTORIES; i++) begin
                coord_x_reg[i] <= '0;
                coord_y_reg[i] <= '0;
                coord_z_reg[i] <= '0;
                slot_reg[i]    <= '0;
            end
        end else if (state_we_c) begin
            coord_x_reg[tr_idx] <= xw_reg;
            coord_y_reg[tr_idx] <= yw_reg;
            coord_z_reg[tr_idx] <= zw_reg;
            slot_reg[tr_idx]    <= slotw_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds a finished result while the next request runs
    // ------------------------------------------------------------------
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

    assign slot_wide = {{SLOT_OUT_W{1'b0}}, slotw_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load_c) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load_c) begin
            m_data_reg.trajectory_out <= req_reg.trajectory;
            m_data_reg.point_x        <= xw_reg;
            m_data_reg.point_y        <= yw_reg;
            m_data_reg.point_z        <= zw_reg;
            m_data_reg.history_slot   <= slot_wide[SLOT_OUT_W-1:0];
            m_data_reg.saturated      <= sat_reg;
        end
    end

    assign s_ready = s_ready_c;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> verif/lorenz_trajectory_stepper_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// lorenz_trajectory_stepper_core_test
// Drives load and step requests into the Lorenz stepper and checks each
// result against an in-bench fixed-point model of the Euler step. The
// requests cover extremes, saturation, history wrap and out-of-range
// trajectories, under several gain settings, random idling and one long
// receiver hold-off.
// ============================================================================

module lorenz_trajectory_stepper_core_test;

    import lts_pkg::*;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     TRAJ_COUNT   = TRAJECTORIES_DEF;
    localparam int     SLOT_COUNT   = HISTORY_DEPTH_DEF;
    localparam longint RATE_CEIL    = 64'sd549755813887;
    localparam longint RATE_FLOOR   = -64'sd549755813888;
    localparam longint COORD_CEIL   = 64'sd2147483647;
    localparam longint COORD_FLOOR  = -64'sd2147483648;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [31:0] MAX_Q24 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q24 = 32'h8000_0000;

    // DUT ports
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    lts_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    lts_out_t              m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Model of the block: gains, step size and every trajectory's point
    longint gain_sigma;
    longint gain_rho;
    longint gain_beta;
    longint euler_dt;
    longint pos_x [TRAJ_COUNT];
    longint pos_y [TRAJ_COUNT];
    longint pos_z [TRAJ_COUNT];
    int     slot_of [TRAJ_COUNT];

    // Points predicted for accepted requests, oldest first
    lts_out_t pending_points [$];

    int error_count = 0;
    int cycle_count = 0;
    int sink_hold   = 0;
    bit steady_flow = 1'b0;

    lorenz_trajectory_stepper_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run if the traffic never drains.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // Round half up to Q8.24 after a Q8.24 x Q8.24 product.
    function automatic longint round_frac(input longint v);
        return (v + 64'sd8388608) >>> 24;
    endfunction

    // Clip into [lo, hi]; raise the flag when clipping happens.
    function automatic longint limit(input longint v, input longint lo, input longint hi,
                                     inout logic flag);
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Apply one request to the model and return the point it reports.
    function automatic lts_out_t advance_point(input lts_in_t req);
        lts_out_t res;
        longint   x, y, z, rx, ry, rz;
        logic     clipped;
        int       t;
        res = '0;
        res.trajectory_out = req.trajectory;
        clipped = 1'b0;
        t = req.trajectory;
        if (t < TRAJ_COUNT) begin
            if (req.operation == OPC_LOAD) begin
                pos_x[t] = longint'(req.load_x);
                pos_y[t] = longint'(req.load_y);
                pos_z[t] = longint'(req.load_z);
                slot_of[t] = 0;
            end else begin
                x = pos_x[t];
                y = pos_y[t];
                z = pos_z[t];
                // all three rates come from the old point
                rx = limit(round_frac(gain_sigma * (y - x)), RATE_FLOOR, RATE_CEIL, clipped);
                ry = limit(round_frac(gain_rho * x) - y + round_frac(x * z),
                           RATE_FLOOR, RATE_CEIL, clipped);
                rz = limit(round_frac(x * y) + round_frac(gain_beta * z),
                           RATE_FLOOR, RATE_CEIL, clipped);
                pos_x[t] = limit(x + round_frac(rx * euler_dt), COORD_FLOOR, COORD_CEIL,
                                 clipped);
                pos_y[t] = limit(y + round_frac(ry * euler_dt), COORD_FLOOR, COORD_CEIL,
                                 clipped);
                pos_z[t] = limit(z - round_frac(rz * euler_dt), COORD_FLOOR, COORD_CEIL,
                                 clipped);
                slot_of[t] = (slot_of[t] + 1 >= SLOT_COUNT) ? 0 : slot_of[t] + 1;
            end
            res.point_x      = pos_x[t][31:0];
            res.point_y      = pos_y[t][31:0];
            res.point_z      = pos_z[t][31:0];
            res.history_slot = slot_of[t][SLOT_OUT_W-1:0];
            res.saturated    = clipped;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    function automatic lts_in_t make_request(input lts_opcode_t op, input int tr,
                                             input logic [31:0] lx, input logic [31:0] ly,
                                             input logic [31:0] lz);
        lts_in_t req;
        req.operation  = op;
        req.trajectory = tr[TRAJ_W-1:0];
        req.load_x     = lx;
        req.load_y     = ly;
        req.load_z     = lz;
        return req;
    endfunction

    // Offer one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance with s_valid still high.
    task automatic send_request(input lts_in_t req);
        // idle now and then, unless the flow is meant to be steady
        while (!steady_flow && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: predict now so later results queue behind
        pending_points.push_back(advance_point(req));
    endtask

    // Drop valid and wait until every predicted point has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Read a register back against the model, then write it. Only call this
    // while the block is idle.
    task automatic program_register(input lts_reg_t idx, input logic [31:0] value);
        logic [31:0] held;
        case (idx)
            REG_SIGMA: held = gain_sigma[31:0];
            REG_RHO:   held = gain_rho[31:0];
            REG_BETA:  held = gain_beta[31:0];
            default:   held = euler_dt[31:0];
        endcase
        // read: setup, then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("register readback", held, prdata);
        // write: keep psel high, start a new setup
        penable <= 1'b0;
        pwrite  <= 1'b1;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // narrow registers drop the upper bits
        case (idx)
            REG_SIGMA: gain_sigma = longint'(value & 32'h7FFF_FFFF);
            REG_RHO:   gain_rho   = longint'(value & 32'h7FFF_FFFF);
            REG_BETA:  gain_beta  = longint'(value & 32'h7FFF_FFFF);
            default:   euler_dt   = longint'(value & 32'h00FF_FFFF);
        endcase
    endtask

    task automatic program_defaults();
        program_register(REG_SIGMA, 32'(SIGMA_RST));
        program_register(REG_RHO, 32'(RHO_RST));
        program_register(REG_BETA, 32'(BETA_RST));
        program_register(REG_TIME_STEP, 32'(DT_RST));
    endtask

    // ------------------------------------------------------------------------
    // Result side: the sink idles at random, or holds m_ready low while
    // sink_hold counts down when a test asks for it.
    // ------------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else begin
                m_ready <= steady_flow || ($urandom_range(99) >= 8);
            end
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        lts_out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %0h", $time, m_data);
            end else begin
                want = pending_points.pop_front();
                check_field("trajectory_out", want.trajectory_out, m_data.trajectory_out);
                check_field("point_x", want.point_x, m_data.point_x);
                check_field("point_y", want.point_y, m_data.point_y);
                check_field("point_z", want.point_z, m_data.point_z);
                check_field("history_slot", want.history_slot, m_data.history_slot);
                check_field("saturated", want.saturated, m_data.saturated);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Step every trajectory from the origin left by reset; it must stay put
    // while the history slot advances.
    task automatic test_reset_state();
        for (int t = 0; t < TRAJ_COUNT; t++)
            send_request(make_request(OPC_STEP, t, $urandom(), $urandom(), $urandom()));
        drain_results();
    endtask

    // Load the corners of the coordinate range and step away from them.
    task automatic test_load_extremes();
        send_request(make_request(OPC_LOAD, 0, MAX_Q24, MAX_Q24, MAX_Q24));
        send_request(make_request(OPC_STEP, 0, '0, '0, '0));
        send_request(make_request(OPC_LOAD, 1, MIN_Q24, MIN_Q24, MIN_Q24));
        send_request(make_request(OPC_STEP, 1, '0, '0, '0));
        send_request(make_request(OPC_LOAD, 2, MAX_Q24, MIN_Q24, '0));
        send_request(make_request(OPC_STEP, 2, MAX_Q24, MAX_Q24, MAX_Q24));
        send_request(make_request(OPC_LOAD, 4, ONE_Q24, ONE_Q24, ONE_Q24));
        send_request(make_request(OPC_STEP, 4, '0, '0, '0));
        drain_results();
    endtask

    // Trajectories past the last one change nothing and report zeros.
    task automatic test_out_of_range();
        send_request(make_request(OPC_STEP, 5, '0, '0, '0));
        send_request(make_request(OPC_LOAD, 6, MAX_Q24, MIN_Q24, ONE_Q24));
        send_request(make_request(OPC_LOAD, 7, MIN_Q24, MAX_Q24, MAX_Q24));
        send_request(make_request(OPC_STEP, 7, MAX_Q24, MAX_Q24, MAX_Q24));
        // trajectory 4 must be untouched by the above
        send_request(make_request(OPC_STEP, 4, '0, '0, '0));
        drain_results();
    endtask

    // Full-scale gains and step force the rate clamp; zero gains and step
    // freeze the point. Writes carry upper bits the registers must drop.
    task automatic test_gain_extremes();
        program_register(REG_SIGMA, 32'hFFFF_FFFF);
        program_register(REG_RHO, 32'hFFFF_FFFF);
        program_register(REG_BETA, 32'hFFFF_FFFF);
        program_register(REG_TIME_STEP, 32'hFFFF_FFFF);
        send_request(make_request(OPC_LOAD, 0, MIN_Q24, MAX_Q24, MAX_Q24));
        send_request(make_request(OPC_STEP, 0, '0, '0, '0));
        send_request(make_request(OPC_LOAD, 1, MIN_Q24, ONE_Q24, MIN_Q24));
        send_request(make_request(OPC_STEP, 1, '0, '0, '0));
        send_request(make_request(OPC_STEP, 1, '0, '0, '0));
        drain_results();
        program_register(REG_SIGMA, '0);
        program_register(REG_RHO, '0);
        program_register(REG_BETA, '0);
        program_register(REG_TIME_STEP, '0);
        send_request(make_request(OPC_STEP, 0, '0, '0, '0));
        send_request(make_request(OPC_STEP, 2, '0, '0, '0));
        drain_results();
    endtask

    // Step one trajectory past the end of the history so its slot wraps.
    task automatic test_slot_wrap();
        program_defaults();
        send_request(make_request(OPC_LOAD, 3, ONE_Q24, ONE_Q24, ONE_Q24));
        repeat (SLOT_COUNT + 3)
            send_request(make_request(OPC_STEP, 3, $urandom(), $urandom(), $urandom()));
        drain_results();
    endtask

    // Hold the sink off for a long stretch while requests keep coming, so
    // the block fills and stalls its input.
    task automatic test_backpressure();
        logic [31:0] v;
        steady_flow = 1'b1;
        sink_hold   = 400;
        for (int i = 0; i < 40; i++) begin
            v = $urandom_range(32'd335544320) - 32'd167772160;
            if (i % 3 == 2)
                send_request(make_request(OPC_STEP, i % TRAJ_COUNT, v, v, v));
            else
                send_request(make_request(OPC_LOAD, i % TRAJ_COUNT, v, ~v, v ^ ONE_Q24));
        end
        drain_results();
        steady_flow = 1'b0;
    endtask

    // Mostly steps on live trajectories with occasional loads, plus a few
    // out-of-range requests as noise.
    task automatic test_random_traffic(input int count);
        lts_in_t     req;
        logic [31:0] span;
        repeat (count) begin
            req.trajectory = ($urandom_range(99) < 6) ? $urandom_range(7, 5)
                                                      : $urandom_range(TRAJ_COUNT - 1, 0);
            req.operation  = ($urandom_range(99) < 12) ? OPC_LOAD : OPC_STEP;
            if (req.operation == OPC_LOAD && $urandom_range(1) == 1) begin
                // start near the attractor: roughly within +-40
                span = 32'd1342177280;
                req.load_x = $urandom_range(span) - (span >> 1);
                req.load_y = $urandom_range(span) - (span >> 1);
                req.load_z = $urandom_range(span) - (span >> 1);
            end else begin
                req.load_x = $urandom();
                req.load_y = $urandom();
                req.load_z = $urandom();
            end
            send_request(req);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        gain_sigma = longint'(SIGMA_RST);
        gain_rho   = longint'(RHO_RST);
        gain_beta  = longint'(BETA_RST);
        euler_dt   = longint'(DT_RST);
        for (int t = 0; t < TRAJ_COUNT; t++) begin
            pos_x[t]   = 0;
            pos_y[t]   = 0;
            pos_z[t]   = 0;
            slot_of[t] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_load_extremes();
        test_out_of_range();
        test_gain_extremes();
        test_slot_wrap();
        test_backpressure();

        // defaults, random idling on both sides
        test_random_traffic(400);

        // arbitrary register contents: saturation most of the time
        program_register(REG_SIGMA, $urandom());
        program_register(REG_RHO, $urandom());
        program_register(REG_BETA, $urandom());
        program_register(REG_TIME_STEP, $urandom());
        test_random_traffic(250);

        // moderate gains, larger step, no idling at all
        program_register(REG_SIGMA, $urandom_range(32'd335544320));
        program_register(REG_RHO, $urandom_range(32'd838860800));
        program_register(REG_BETA, $urandom_range(32'd83886080));
        program_register(REG_TIME_STEP, $urandom_range(32'd4194304));
        steady_flow = 1'b1;
        test_random_traffic(400);
        steady_flow = 1'b0;

        program_defaults();
        test_random_traffic(300);

        // let any late or stray result show up
        repeat (80) @(posedge aclk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
